[rtl/core/bptc_pkg.sv]
// Shared types and constants for the barometric compensation pipeline.
package bptc_pkg;

    localparam int NUM_STAGES   = 11;
    localparam int TEMP_REF     = 2000;
    localparam int TEMP_VLOW    = -1500;
    localparam int TEMP_OUT_MAX = 262143;
    localparam int TEMP_OUT_MIN = -262144;

    typedef enum logic [2:0] {
        CAL_SENS     = 3'd0,
        CAL_OFF      = 3'd1,
        CAL_TCS      = 3'd2,
        CAL_TCO      = 3'd3,
        CAL_TREF     = 3'd4,
        CAL_TEMPSENS = 3'd5
    } bptc_cal_idx_t;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] off;
        logic [15:0] tcs;
        logic [15:0] tco;
        logic [15:0] tref;
        logic [15:0] tempsens;
    } bptc_cal_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } bptc_pipe_ctl_t;

endpackage

[rtl/core/baro_pressure_temp_compensation.sv]
// Top level of the barometric pressure and temperature compensation block.
//
// The block turns one raw pressure and temperature conversion pair into a
// compensated temperature in 0.01 C and pressure in 0.01 mbar, including the
// second-order low-temperature correction, using six calibration words written
// through the configuration port (always ready; indexes above five are dropped).
// It is an eleven-register pipeline: it takes one transfer per cycle sustained
// while the output side does not stall, and each result is registered in every
// stage before it is presented. Stall on the output side backs up only the
// stages that are full, so empty stages keep accepting. The widest step, the
// pressure multiply, is split into two partial products summed in the next
// stage.
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [23:0]        s_raw_pressure,
    input  logic [23:0]        s_raw_temperature,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [18:0] m_temperature_centi,
    output logic signed [31:0] m_pressure_centi_mbar,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    bptc_cal_t          cal_reg;
    bptc_cal_t          cal_next;
    bptc_pipe_ctl_t     ctl;
    logic [23:0]        d1_mid;
    logic signed [18:0] temp_mid;
    logic signed [39:0] off_mid;
    logic signed [39:0] sens_mid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (bptc_cal_idx_t'(cfg_index))
                CAL_SENS:     cal_next.sens     = cfg_data;
                CAL_OFF:      cal_next.off      = cfg_data;
                CAL_TCS:      cal_next.tcs      = cfg_data;
                CAL_TCO:      cal_next.tco      = cfg_data;
                CAL_TREF:     cal_next.tref     = cfg_data;
                CAL_TEMPSENS: cal_next.tempsens = cfg_data;
                default:      cal_next          = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    bptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    bptc_front u_front (
        .aclk            (aclk),
        .ctl             (ctl),
        .cal             (cal_reg),
        .raw_pressure    (s_raw_pressure),
        .raw_temperature (s_raw_temperature),
        .d1_out          (d1_mid),
        .temp_out        (temp_mid),
        .off_out         (off_mid),
        .sens_out        (sens_mid)
    );

    bptc_press u_press (
        .aclk     (aclk),
        .ctl      (ctl),
        .d1_in    (d1_mid),
        .temp_in  (temp_mid),
        .off_in   (off_mid),
        .sens_in  (sens_mid),
        .temp_out (m_temperature_centi),
        .pres_out (m_pressure_centi_mbar)
    );

    // An empty output stage lets the whole pipeline advance.
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output stage was empty");

    // A taken output frees every stage behind it.
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the output side was ready");

    // A reference temperature write lands in the calibration register.
    a_cfg_tref: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == CAL_TREF) |=> cal_reg.tref == $past(cfg_data))
        else $error("reference temperature write was lost");

endmodule

[rtl/core/bptc_ctrl.sv]
// Valid tracking and per-stage load enables for the compensation pipeline.
module bptc_ctrl
    import bptc_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output bptc_pipe_ctl_t ctl
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];
    assign ctl.en  = en;

endmodule

[rtl/core/bptc_front.sv]
// First- and second-order temperature, offset and sensitivity stages.
module bptc_front
    import bptc_pkg::*;
(
    input  logic               aclk,
    input  bptc_pipe_ctl_t     ctl,
    input  bptc_cal_t          cal,
    input  logic [23:0]        raw_pressure,
    input  logic [23:0]        raw_temperature,
    output logic [23:0]        d1_out,
    output logic signed [18:0] temp_out,
    output logic signed [39:0] off_out,
    output logic signed [39:0] sens_out
);

    // Stage 0
    logic signed [24:0] dt_next, dt_reg;
    logic [23:0]        d1_s0_reg;

    // Stage 1
    logic signed [41:0] pt_next, pt_reg;
    logic signed [41:0] poff_next, poff_reg;
    logic signed [41:0] psens_next, psens_reg;
    logic signed [49:0] pdd_next, pdd_reg;
    logic [23:0]        d1_s1_reg;

    // Stage 2
    logic signed [41:0] qt_full, qoff_full, qsens_full;
    logic signed [18:0] qt;
    logic signed [34:0] qoff;
    logic signed [33:0] qsens;
    logic signed [19:0] temp1_next, temp1_reg;
    logic signed [36:0] off1_next, off1_reg;
    logic signed [35:0] sens1_next, sens1_reg;
    logic [17:0]        t2_next, t2_reg;
    logic [23:0]        d1_s2_reg;

    // Stage 3
    logic signed [20:0] a_val, b_val;
    logic signed [41:0] a2_next, a2_reg;
    logic signed [41:0] b2_next, b2_reg;
    logic               low_next, low_reg;
    logic               vlow_next, vlow_reg;
    logic [20:0]        tsub;
    logic signed [20:0] temp2_next, temp2_reg;
    logic signed [36:0] off1_s3_reg;
    logic signed [35:0] sens1_s3_reg;
    logic [23:0]        d1_s3_reg;

    // Stage 4
    logic signed [47:0] a2w, b2w, five_a2, seven_b2, eleven_b2;
    logic signed [47:0] off2_next, off2_reg;
    logic signed [47:0] sens2_next, sens2_reg;
    logic signed [18:0] tsat_next, tsat_reg;
    logic signed [36:0] off1_s4_reg;
    logic signed [35:0] sens1_s4_reg;
    logic [23:0]        d1_s4_reg;

    // Stage 5
    logic signed [47:0] off_full, sens_full;
    logic signed [39:0] off_reg, sens_reg;
    logic signed [18:0] temp_s5_reg;
    logic [23:0]        d1_s5_reg;

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.tref, 8'd0});

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            dt_reg    <= dt_next;
            d1_s0_reg <= raw_pressure;
        end
    end

    assign pt_next    = dt_reg * $signed({1'b0, cal.tempsens});
    assign poff_next  = dt_reg * $signed({1'b0, cal.tco});
    assign psens_next = dt_reg * $signed({1'b0, cal.tcs});
    assign pdd_next   = dt_reg * dt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            pt_reg    <= pt_next;
            poff_reg  <= poff_next;
            psens_reg <= psens_next;
            pdd_reg   <= pdd_next;
            d1_s1_reg <= d1_s0_reg;
        end
    end

    // Adding 2^k-1 to negative values makes the arithmetic shift truncate toward zero.
    assign qt_full    = pt_reg + $signed({{19{1'b0}}, {23{pt_reg[41]}}});
    assign qoff_full  = poff_reg + $signed({{35{1'b0}}, {7{poff_reg[41]}}});
    assign qsens_full = psens_reg + $signed({{34{1'b0}}, {8{psens_reg[41]}}});
    assign qt         = qt_full[41:23];
    assign qoff       = qoff_full[41:7];
    assign qsens      = qsens_full[41:8];
    assign temp1_next = $signed({qt[18], qt}) + 20'(TEMP_REF);
    assign off1_next  = $signed({5'd0, cal.off, 16'd0}) + $signed({{2{qoff[34]}}, qoff});
    assign sens1_next = $signed({5'd0, cal.sens, 15'd0}) + $signed({{2{qsens[33]}}, qsens});
    assign t2_next    = pdd_reg[48:31];

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            temp1_reg <= temp1_next;
            off1_reg  <= off1_next;
            sens1_reg <= sens1_next;
            t2_reg    <= t2_next;
            d1_s2_reg <= d1_s1_reg;
        end
    end

    assign a_val      = $signed({temp1_reg[19], temp1_reg}) - 21'(TEMP_REF);
    assign b_val      = $signed({temp1_reg[19], temp1_reg}) - 21'(TEMP_VLOW);
    assign a2_next    = a_val * a_val;
    assign b2_next    = b_val * b_val;
    assign low_next   = temp1_reg < 20'(TEMP_REF);
    assign vlow_next  = temp1_reg < 20'(TEMP_VLOW);
    assign tsub       = low_next ? {3'd0, t2_reg} : 21'd0;
    assign temp2_next = $signed({temp1_reg[19], temp1_reg}) - $signed(tsub);

    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            a2_reg       <= a2_next;
            b2_reg       <= b2_next;
            low_reg      <= low_next;
            vlow_reg     <= vlow_next;
            temp2_reg    <= temp2_next;
            off1_s3_reg  <= off1_reg;
            sens1_s3_reg <= sens1_reg;
            d1_s3_reg    <= d1_s2_reg;
        end
    end

    // The squares are never negative, so plain shifts give the truncated quotients.
    assign a2w       = $signed({{6{a2_reg[41]}}, a2_reg});
    assign b2w       = $signed({{6{b2_reg[41]}}, b2_reg});
    assign five_a2   = (a2w <<< 2) + a2w;
    assign seven_b2  = (b2w <<< 3) - b2w;
    assign eleven_b2 = (b2w <<< 3) + (b2w <<< 1) + b2w;

    always_comb begin
        off2_next  = '0;
        sens2_next = '0;
        if (low_reg) begin
            off2_next  = five_a2 >>> 1;
            sens2_next = five_a2 >>> 2;
            if (vlow_reg) begin
                off2_next  = (five_a2 >>> 1) + seven_b2;
                sens2_next = (five_a2 >>> 2) + (eleven_b2 >>> 1);
            end
        end
    end

    always_comb begin
        priority if (temp2_reg > 21'(TEMP_OUT_MAX)) begin
            tsat_next = 19'(TEMP_OUT_MAX);
        end else if (temp2_reg < 21'(TEMP_OUT_MIN)) begin
            tsat_next = 19'(TEMP_OUT_MIN);
        end else begin
            tsat_next = temp2_reg[18:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[4]) begin
            off2_reg     <= off2_next;
            sens2_reg    <= sens2_next;
            tsat_reg     <= tsat_next;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            d1_s4_reg    <= d1_s3_reg;
        end
    end

    assign off_full  = $signed({{11{off1_s4_reg[36]}}, off1_s4_reg}) - off2_reg;
    assign sens_full = $signed({{12{sens1_s4_reg[35]}}, sens1_s4_reg}) - sens2_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[5]) begin
            off_reg     <= off_full[39:0];
            sens_reg    <= sens_full[39:0];
            temp_s5_reg <= tsat_reg;
            d1_s5_reg   <= d1_s4_reg;
        end
    end

    assign d1_out   = d1_s5_reg;
    assign temp_out = temp_s5_reg;
    assign off_out  = off_reg;
    assign sens_out = sens_reg;

endmodule

[rtl/core/bptc_press.sv]
// Pressure stages: split D1 by SENS product, scaling and offset removal.
module bptc_press
    import bptc_pkg::*;
(
    input  logic               aclk,
    input  bptc_pipe_ctl_t     ctl,
    input  logic [23:0]        d1_in,
    input  logic signed [18:0] temp_in,
    input  logic signed [39:0] off_in,
    input  logic signed [39:0] sens_in,
    output logic signed [18:0] temp_out,
    output logic signed [31:0] pres_out
);

    logic [43:0]        pl_next, pl_reg;
    logic signed [44:0] ph_next, ph_reg;
    logic signed [64:0] prod_next, prod_reg;
    logic signed [64:0] q1_full;
    logic signed [43:0] q1_reg;
    logic signed [44:0] x_next, x_reg;
    logic signed [44:0] xq_full;
    logic signed [29:0] pq;
    logic signed [31:0] pres_reg;
    logic signed [39:0] off_s6_reg, off_s7_reg, off_s8_reg;
    logic signed [18:0] temp_s6_reg, temp_s7_reg, temp_s8_reg, temp_s9_reg, temp_s10_reg;

    assign pl_next = d1_in * sens_in[19:0];
    assign ph_next = $signed({1'b0, d1_in}) * $signed(sens_in[39:20]);

    always_ff @(posedge aclk) begin
        if (ctl.en[6]) begin
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            off_s6_reg  <= off_in;
            temp_s6_reg <= temp_in;
        end
    end

    assign prod_next = $signed({ph_reg, 20'd0}) + $signed({21'd0, pl_reg});

    always_ff @(posedge aclk) begin
        if (ctl.en[7]) begin
            prod_reg    <= prod_next;
            off_s7_reg  <= off_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
    end

    assign q1_full = prod_reg + $signed({{44{1'b0}}, {21{prod_reg[64]}}});

    always_ff @(posedge aclk) begin
        if (ctl.en[8]) begin
            q1_reg      <= q1_full[64:21];
            off_s8_reg  <= off_s7_reg;
            temp_s8_reg <= temp_s7_reg;
        end
    end

    assign x_next = $signed({q1_reg[43], q1_reg}) - $signed({{5{off_s8_reg[39]}}, off_s8_reg});

    always_ff @(posedge aclk) begin
        if (ctl.en[9]) begin
            x_reg       <= x_next;
            temp_s9_reg <= temp_s8_reg;
        end
    end

    // The quotient spans 30 bits, so it always fits the 32-bit result.
    assign xq_full = x_reg + $signed({{30{1'b0}}, {15{x_reg[44]}}});
    assign pq      = xq_full[44:15];

    always_ff @(posedge aclk) begin
        if (ctl.en[10]) begin
            pres_reg     <= $signed({{2{pq[29]}}, pq});
            temp_s10_reg <= temp_s9_reg;
        end
    end

    assign temp_out = temp_s10_reg;
    assign pres_out = pres_reg;

endmodule
